// File: rtl/assert_macros.svh
// Assertion macros shared by the histogram counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, ignored while reset is held
`define VHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("histogram counter assertion failed");
// Checked property, also evaluated across reset
`define VHC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("histogram counter reset assertion failed");
`else
`define VHC_ASSERT(label, prop)
`define VHC_ASSERT_RST(label, prop)
`endif
`endif

// File: rtl/vhc_pkg.sv
// Package: sizes, state codes and control structs of the histogram counter.
`default_nettype none
package vhc_pkg;

  localparam int BINS        = 1024;
  localparam int COUNT_WIDTH = 32;
  localparam int SAMPLE_W    = 32;
  localparam int FRAC_BITS   = 8;
  localparam int INDEX_W     = 10;
  localparam int USED_W      = 11;
  localparam int ADDR_W      = $clog2(BINS);
  // whole part of a non-negative sample (sign bit excluded)
  localparam int WHOLE_W     = SAMPLE_W - 1 - FRAC_BITS;

  // controller state codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_UPD   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic update;
  } vhc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } vhc_sts_t;

endpackage
`default_nettype wire

// File: rtl/vhc_ctrl.sv
// Controller: clearing sweep, sample intake and bin update sequencing.
`default_nettype none
`include "assert_macros.svh"
module vhc_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               sample_valid,
  output logic              sample_stall,
  input  vhc_pkg::vhc_sts_t sts,
  output vhc_pkg::vhc_cmd_t cmd
);
  import vhc_pkg::*;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        // wait for the result register to free up
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // checks
  `VHC_ASSERT_RST(a_reset_clears, $past(rst) |-> state == ST_CLEAR)
  `VHC_ASSERT(a_accept_then_upd, cmd.accept |=> state == ST_UPD)
  `VHC_ASSERT(a_update_needs_room, cmd.update |-> sts.out_free)
  `VHC_ASSERT(a_one_cmd, $onehot0({cmd.clear_wr, cmd.accept, cmd.update}))

endmodule
`default_nettype wire

// File: rtl/vhc_datapath.sv
// Datapath: bin count memory, read-modify-write, range tracking and result register.
`default_nettype none
`include "assert_macros.svh"
module vhc_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  signed [vhc_pkg::SAMPLE_W-1:0] sample,
  input  vhc_pkg::vhc_cmd_t                   cmd,
  output vhc_pkg::vhc_sts_t                   sts,
  output logic                                result_valid,
  input  wire                                 result_stall,
  output logic [vhc_pkg::INDEX_W-1:0]         bin_index,
  output logic [vhc_pkg::COUNT_WIDTH-1:0]     bin_count,
  output logic                                skipped_negative,
  output logic                                out_of_range,
  output logic [vhc_pkg::USED_W-1:0]          bins_in_use
);
  import vhc_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [BINS];

  logic [ADDR_W-1:0]      clr_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [ADDR_W-1:0]      pend_addr;
  logic                   pend_neg;
  logic                   pend_oor;
  logic [USED_W-1:0]      used_bins;
  logic [USED_W-1:0]      used_bins_next;

  logic [WHOLE_W-1:0]     whole;
  logic                   in_neg;
  logic                   in_oor;
  logic [ADDR_W-1:0]      in_addr;
  logic                   counted;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [USED_W-1:0]      cand;

  // decode the incoming sample
  assign in_neg  = sample[SAMPLE_W-1];
  assign whole   = sample[SAMPLE_W-2:FRAC_BITS];
  assign in_oor  = !in_neg && (whole >= WHOLE_W'(BINS));
  assign in_addr = whole[ADDR_W-1:0];

  // increment with saturation
  assign counted = cmd.update && !pend_neg && !pend_oor;
  assign cnt_new = (rd_data == '1) ? rd_data : rd_data + 1'b1;

  // range tracking: highest counted bin plus one
  assign cand = USED_W'(pend_addr) + 1'b1;
  always_comb begin
    used_bins_next = used_bins;
    if (counted && (cand > used_bins)) used_bins_next = cand;
  end

  assign sts.clear_last = (clr_addr == ADDR_W'(BINS - 1));
  assign sts.out_free   = !result_valid || !result_stall;

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[clr_addr] <= '0;
    end else if (counted) begin
      mem[pend_addr] <= cnt_new;
    end
  end

  // memory read port, taken with the transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data <= mem[in_addr];
    end
  end

  // pending sample decode
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_addr <= in_addr;
      pend_neg  <= in_neg;
      pend_oor  <= in_oor;
    end
  end

  // bins in use
  always_ff @(posedge clk) begin
    if (rst) begin
      used_bins <= USED_W'(1);
    end else begin
      used_bins <= used_bins_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.update) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      bin_index        <= counted ? INDEX_W'(pend_addr) : '0;
      bin_count        <= counted ? cnt_new : '0;
      skipped_negative <= pend_neg;
      out_of_range     <= pend_oor;
      bins_in_use      <= used_bins_next;
    end
  end

  // checks
  `VHC_ASSERT(a_flags_exclusive, result_valid |-> $onehot0({skipped_negative, out_of_range}))
  `VHC_ASSERT(a_skip_no_count, result_valid && (skipped_negative || out_of_range) |-> bin_count == '0)
  `VHC_ASSERT(a_used_nonzero, used_bins != '0)
  `VHC_ASSERT(a_count_nonzero, result_valid && !skipped_negative && !out_of_range |-> bin_count != '0)

endmodule
`default_nettype wire

// File: rtl/value_histogram_counter_unit.sv
// Histogram counter unit: per-bin sample counts with a saturating memory.
//
// Input channel: sample (signed, 8 fraction bits) with sample_valid/sample_stall.
// Output channel: bin_index, bin_count, skipped_negative, out_of_range and
// bins_in_use with result_valid/result_stall; one result per sample.
// After reset the unit clears its 1024-entry count memory, one entry a cycle,
// holding sample_stall high until the sweep ends; the range tracker restarts at one.
// A transaction accepted in the idle state is read from the memory as it is taken;
// in the update state it is written back and loaded into the result register, so
// result_valid is set once the result register is free. A new sample is taken only
// after the last one is written back, as its read and write-back occupy separate states.
// A result held under result_stall stays put; the next sample is still taken,
// and its update waits until the held result has been delivered, so a stalled
// receiver throttles intake to its own pace without losing transactions.
// Negative samples and whole parts of 1024 or more leave the counts unchanged.
`default_nettype none
module value_histogram_counter_unit (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 sample_valid,
  output logic                                sample_stall,
  input  wire  signed [vhc_pkg::SAMPLE_W-1:0] sample,
  output logic                                result_valid,
  input  wire                                 result_stall,
  output logic [vhc_pkg::INDEX_W-1:0]         bin_index,
  output logic [vhc_pkg::COUNT_WIDTH-1:0]     bin_count,
  output logic                                skipped_negative,
  output logic                                out_of_range,
  output logic [vhc_pkg::USED_W-1:0]          bins_in_use
);
  import vhc_pkg::*;

  vhc_cmd_t cmd;
  vhc_sts_t sts;

  // sequencing
  vhc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // storage and arithmetic
  vhc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .sample           (sample),
    .cmd              (cmd),
    .sts              (sts),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .bin_index        (bin_index),
    .bin_count        (bin_count),
    .skipped_negative (skipped_negative),
    .out_of_range     (out_of_range),
    .bins_in_use      (bins_in_use)
  );

endmodule
`default_nettype wire
